FILE: sv/cab_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the clipped alpha blitter.
// No dependencies; the files that use this package refer to it by scoped names.
package cab_pkg;

  localparam int FRAME_WIDTH_MAX  = 64;
  localparam int FRAME_HEIGHT_MAX = 64;
  localparam int STORE_DEPTH      = FRAME_WIDTH_MAX * FRAME_HEIGHT_MAX;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  // wide enough for frame sizes up to 1024 and for dest plus counter sums
  localparam int CMP_W            = 11;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 3'd6;

  // pixel_mode bits
  localparam int MODE_SRC_ALPHA = 0;
  localparam int MODE_IGNORE    = 1;
  localparam int MODE_TGT_ALPHA = 2;

  typedef enum logic [1:0] {
    FUNC_BLIT = 2'd0,
    FUNC_LOAD = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] pixel_x;
    logic [5:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       written;
    logic       last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
  } cmd_t;

endpackage

FILE: sv/cab_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module cab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cab_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, rectangle counters, clipping, frame store
// and blend arithmetic. Depends on cab_pkg and cab_ram.
module cab_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cab_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  cab_pkg::in_t                   in_data_i,
  input  cab_pkg::cmd_t                  cmd_i,
  output cab_pkg::out_t                  out_data_o
);

  localparam int AW = cab_pkg::ADDR_W;
  localparam int CW = cab_pkg::CMP_W;

  logic [6:0] frame_width_q, frame_height_q;
  logic [7:0] dest_x_q, dest_y_q, rect_width_q, rect_height_q;
  logic [2:0] pixel_mode_q;
  logic [7:0] col_q, col_d, row_q, row_d;

  logic                 inside_q, inside_d;
  logic                 last_q, last_d;
  logic [AW-1:0]        addr_q, addr_d;
  cab_pkg::func_e       op_q;
  cab_pkg::pixel_t      pix_q;
  cab_pkg::out_t        out_q, out_d;

  cab_pkg::pixel_t      tgt;
  cab_pkg::pixel_t      new_pix;
  logic [31:0]          rdata;
  logic                 wr_en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 7'd64;
      frame_height_q <= 7'd64;
      dest_x_q       <= '0;
      dest_y_q       <= '0;
      rect_width_q   <= 8'd1;
      rect_height_q  <= 8'd1;
      pixel_mode_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cab_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[6:0];
        cab_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[6:0];
        cab_pkg::CFG_DEST_X:       dest_x_q       <= cfg_wdata_i;
        cab_pkg::CFG_DEST_Y:       dest_y_q       <= cfg_wdata_i;
        cab_pkg::CFG_RECT_WIDTH:   rect_width_q   <= cfg_wdata_i;
        cab_pkg::CFG_RECT_HEIGHT:  rect_height_q  <= cfg_wdata_i;
        cab_pkg::CFG_PIXEL_MODE:   pixel_mode_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // capture stage: position, clip test and rectangle bookkeeping
  logic [CW-1:0] eff_w, eff_h, x_pos, y_pos, px_pos, py_pos;
  logic          row_end, rect_end;

  always_comb begin
    eff_w = (CW'(frame_width_q) < CW'(cab_pkg::FRAME_WIDTH_MAX)) ?
            CW'(frame_width_q) : CW'(cab_pkg::FRAME_WIDTH_MAX);
    eff_h = (CW'(frame_height_q) < CW'(cab_pkg::FRAME_HEIGHT_MAX)) ?
            CW'(frame_height_q) : CW'(cab_pkg::FRAME_HEIGHT_MAX);
    x_pos  = CW'(dest_x_q) + CW'(col_q);
    y_pos  = CW'(dest_y_q) + CW'(row_q);
    px_pos = CW'(in_data_i.pixel_x);
    py_pos = CW'(in_data_i.pixel_y);

    row_end  = (CW'(col_q) + CW'(1)) >= CW'(rect_width_q);
    rect_end = row_end && ((CW'(row_q) + CW'(1)) >= CW'(rect_height_q));

    col_d    = col_q;
    row_d    = row_q;
    inside_d = 1'b0;
    last_d   = 1'b0;
    addr_d   = '0;
    case (cab_pkg::func_e'(in_data_i.func))
      cab_pkg::FUNC_BLIT: begin
        inside_d = (x_pos < eff_w) && (y_pos < eff_h);
        addr_d   = AW'(y_pos) * AW'(cab_pkg::FRAME_WIDTH_MAX) + AW'(x_pos);
        last_d   = rect_end;
        if (row_end) begin
          col_d = '0;
          row_d = rect_end ? 8'd0 : row_q + 8'd1;
        end else begin
          col_d = col_q + 8'd1;
        end
      end
      cab_pkg::FUNC_LOAD, cab_pkg::FUNC_READ: begin
        inside_d = (px_pos < CW'(cab_pkg::FRAME_WIDTH_MAX)) &&
                   (py_pos < CW'(cab_pkg::FRAME_HEIGHT_MAX));
        addr_d   = AW'(py_pos) * AW'(cab_pkg::FRAME_WIDTH_MAX) + AW'(px_pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= cab_pkg::func_e'(in_data_i.func);
      inside_q  <= inside_d;
      last_q    <= last_d;
      addr_q    <= addr_d;
      pix_q     <= '{alpha: in_data_i.alpha, blue: in_data_i.blue,
                     green: in_data_i.green, red: in_data_i.red};
    end
  end

  cab_ram #(
    .WIDTH(32),
    .DEPTH(cab_pkg::STORE_DEPTH)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit && wr_en),
    .waddr_i(addr_q),
    .wdata_i(new_pix),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign tgt = cab_pkg::pixel_t'(rdata);

  // blend: ((256 - a) * target + a * source) >> 8
  logic [8:0]  inv_a;
  logic [16:0] sum_r, sum_g, sum_b;

  always_comb begin
    inv_a = 9'd256 - 9'(pix_q.alpha);
    sum_r = 17'(inv_a * 17'(tgt.red))   + 17'(pix_q.alpha * 16'(pix_q.red));
    sum_g = 17'(inv_a * 17'(tgt.green)) + 17'(pix_q.alpha * 16'(pix_q.green));
    sum_b = 17'(inv_a * 17'(tgt.blue))  + 17'(pix_q.alpha * 16'(pix_q.blue));
  end

  // execute stage: pick the new target pixel and the result
  logic blend_mode;

  always_comb begin
    blend_mode = pixel_mode_q[cab_pkg::MODE_SRC_ALPHA] &&
                 !pixel_mode_q[cab_pkg::MODE_IGNORE];
    wr_en   = 1'b0;
    new_pix = pix_q;
    out_d   = '0;
    case (op_q)
      cab_pkg::FUNC_BLIT: begin
        if (blend_mode) begin
          new_pix = '{alpha: tgt.alpha, blue: sum_b[15:8],
                      green: sum_g[15:8], red: sum_r[15:8]};
          wr_en   = inside_q && (pix_q.alpha != 8'd0);
        end else begin
          // copy alpha only when ignore, source alpha and target alpha are set
          if (!(pixel_mode_q[cab_pkg::MODE_IGNORE] &&
                pixel_mode_q[cab_pkg::MODE_SRC_ALPHA] &&
                pixel_mode_q[cab_pkg::MODE_TGT_ALPHA])) begin
            new_pix.alpha = tgt.alpha;
          end
          wr_en = inside_q;
        end
        if (wr_en) begin
          out_d.out_red   = new_pix.red;
          out_d.out_green = new_pix.green;
          out_d.out_blue  = new_pix.blue;
          out_d.out_alpha = new_pix.alpha;
        end
        out_d.written = wr_en;
        out_d.last    = last_q;
      end
      cab_pkg::FUNC_LOAD: begin
        wr_en = inside_q;
        if (inside_q) begin
          out_d.out_red   = pix_q.red;
          out_d.out_green = pix_q.green;
          out_d.out_blue  = pix_q.blue;
          out_d.out_alpha = pix_q.alpha;
        end
      end
      cab_pkg::FUNC_READ: begin
        if (inside_q) begin
          out_d.out_red   = tgt.red;
          out_d.out_green = tgt.green;
          out_d.out_blue  = tgt.blue;
          out_d.out_alpha = tgt.alpha;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: sv/cab_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences capture, store read and execute for one request and
// owns the output valid flag. Depends on cab_pkg.
module cab_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cab_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, commit;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  // the result register is free when empty or being drained this cycle
  assign commit = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.rd_en   = (state_q == ST_READ);
  assign cmd_o.commit  = commit;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ))
    else $error("accepted request did not move to store read");

  a_read_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_EXEC))
    else $error("store read not followed by execute");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");

  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EXEC) && out_valid_q && out_stall_i) |=> (state_q == ST_EXEC))
    else $error("execute left while result register was full");

endmodule

FILE: sv/clipped_alpha_blit.sv
`timescale 1ns / 1ps
// Top level of the clipped alpha blitter: controller plus datapath.
// Depends on cab_pkg, cab_ctrl, cab_datapath and cab_ram.
//
//   port group    direction  handshake              payload
//   in            request in in_valid_i / in_stall_o  in_data_i (cab_pkg::in_t)
//   out           result out out_valid_o / out_stall_i out_data_o (cab_pkg::out_t)
//   cfg           write      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Each request passes through capture, frame store read and execute.
// The registered frame store read lies ahead of the write-back.
// The result register lets the next request enter while a result waits;
// execute holds while that register is full and stalled.
// Reset restores control, counters and configuration; pipeline, result registers and frame store are not cleared.
module clipped_alpha_blit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cab_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cab_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cab_pkg::out_t                  out_data_o
);

  cab_pkg::cmd_t cmd;

  cab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  cab_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

endmodule
